// ----- rtl/core/red_pkg.sv -----
// Shared types, constants and decode tables for the rotary encoder decoder.
`timescale 1ns / 1ps

package red_pkg;

	// Step flags and masks of a table entry.
	localparam logic [7:0] STEP_CW   = 8'h10;
	localparam logic [7:0] STEP_CCW  = 8'h20;
	localparam logic [7:0] STEP_MASK = 8'h30;
	localparam logic [7:0] NEXT_MASK = 8'h0f;

	localparam int STATE_W = 3;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	// Configuration register indexes (taken from paddr[2]).
	localparam logic REG_HALF_STEP = 1'b0;
	localparam logic REG_SWITCH    = 1'b1;

	// Input beat commands.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	localparam logic [STATE_W-1:0] START_STATE = 3'd0;
	localparam logic [STATE_W-1:0] FULL_ROWS   = 3'd7;
	localparam logic [STATE_W-1:0] HALF_ROWS   = 3'd6;

	localparam logic signed [1:0] DIR_ZERO = 2'sb00;
	localparam logic signed [1:0] DIR_CW   = 2'sb01;
	localparam logic signed [1:0] DIR_CCW  = 2'sb11;

	// Rows by state, columns by code 00, 01, 10, 11.
	localparam logic [7:0] FULL_TAB [0:6][0:3] = '{
		'{8'h00, 8'h02, 8'h04, 8'h00},
		'{8'h03, 8'h00, 8'h01, 8'h10},
		'{8'h03, 8'h02, 8'h00, 8'h00},
		'{8'h03, 8'h02, 8'h01, 8'h00},
		'{8'h06, 8'h00, 8'h04, 8'h00},
		'{8'h06, 8'h05, 8'h00, 8'h20},
		'{8'h06, 8'h05, 8'h04, 8'h00}
	};

	localparam logic [7:0] HALF_TAB [0:5][0:3] = '{
		'{8'h03, 8'h02, 8'h01, 8'h00},
		'{8'h23, 8'h00, 8'h01, 8'h00},
		'{8'h13, 8'h02, 8'h00, 8'h00},
		'{8'h03, 8'h05, 8'h04, 8'h00},
		'{8'h03, 8'h03, 8'h04, 8'h10},
		'{8'h03, 8'h05, 8'h03, 8'h20}
	};

	// Outcome of one table lookup.
	typedef struct packed {
		logic [STATE_W-1:0] next_state;
		logic               cw;
		logic               ccw;
	} lookup_t;

endpackage

// ----- rtl/core/red_channels.sv -----
// Valid/ready channel interfaces for encoder samples and decoded results.
`timescale 1ns / 1ps

interface red_item_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic               pin_a;
	logic               pin_b;
	logic               pin_button;
	logic signed [31:0] load_value;

	modport source (output valid, cmd, pin_a, pin_b, pin_button, load_value, input ready);
	modport sink (input valid, cmd, pin_a, pin_b, pin_button, load_value, output ready);
endinterface

interface red_result_if;
	logic               valid;
	logic               ready;
	logic               has_event;
	logic signed [1:0]  direction;
	logic signed [31:0] count;
	logic               button;

	modport source (output valid, has_event, direction, count, button, input ready);
	modport sink (input valid, has_event, direction, count, button, output ready);
endinterface

// ----- rtl/core/red_step_table.sv -----
// Gray-code state table lookup for full-step and half-step decoding.
`timescale 1ns / 1ps

module red_step_table
	import red_pkg::*;
(
	input  logic               half_sel,
	input  logic [STATE_W-1:0] state,
	input  logic [1:0]         code,
	output lookup_t            result
);

	always_comb begin
		logic [STATE_W-1:0] row;
		logic [7:0]         entry;
		logic [7:0]         flags;
		// A state with no row in the selected table reads as the start state.
		row = state;
		if (half_sel) begin
			if (row >= HALF_ROWS) begin
				row = START_STATE;
			end
			entry = HALF_TAB[row][code];
		end else begin
			if (row >= FULL_ROWS) begin
				row = START_STATE;
			end
			entry = FULL_TAB[row][code];
		end
		flags             = entry & STEP_MASK;
		result.next_state = STATE_W'(entry & NEXT_MASK);
		result.cw         = (flags == STEP_CW);
		result.ccw        = (flags == STEP_CCW);
	end

endmodule

// ----- rtl/core/rotary_encoder_decoder.sv -----
// Top level of the rotary encoder decoder: input stage, decode stage, APB registers.
//
//   channel   direction  beat contents
//   item      sink       cmd, pin_a, pin_b, pin_button, load_value
//   result    source     has_event, direction, count, button
//   apb       slave      half_step_mode (0x0), switch_present (0x4)
//
// Each beat passes through the input register, then through the table lookup and
// counter adder into the result register.
// A new beat is accepted every cycle while the result side keeps taking beats.
// A stalled result holds the decode stage, and the input register fills behind it.
// Reset clears the table state, counter and button latch; half-step mode off, button present.
`timescale 1ns / 1ps

module rotary_encoder_decoder
	import red_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	red_item_if.sink           item,
	red_result_if.source       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	logic                   half_step_q;
	logic                   switch_present_q;

	logic                   valid_s1;
	logic                   cmd_s1;
	logic [1:0]             code_s1;
	logic                   pin_button_s1;
	logic signed [31:0]     load_value_s1;

	logic [STATE_W-1:0]     table_state_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   button_q;

	logic                   out_valid_q;
	logic                   has_event_q;
	logic signed [1:0]      direction_q;
	logic signed [31:0]     count_out_q;
	logic                   button_out_q;

	logic                   advance;
	logic                   fire;
	lookup_t                lk;
	logic [COUNT_WIDTH-1:0] load_ext;
	logic [COUNT_WIDTH-1:0] count_next;
	logic                   pressed;
	logic                   button_next;
	logic [STATE_W-1:0]     state_next;
	logic                   event_next;
	logic signed [1:0]      dir_next;

	// Configuration port.
	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			REG_HALF_STEP: prdata = {{(DATA_W-1){1'b0}}, half_step_q};
			REG_SWITCH:    prdata = {{(DATA_W-1){1'b0}}, switch_present_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_step_q      <= 1'b0;
			switch_present_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_HALF_STEP: half_step_q      <= pwdata[0];
				REG_SWITCH:    switch_present_q <= pwdata[0];
				default:       ;
			endcase
		end
	end

	// Handshake: the decode stage moves whenever the result register is free.
	assign advance    = !out_valid_q || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			cmd_s1        <= item.cmd;
			code_s1       <= {item.pin_a, item.pin_b};
			pin_button_s1 <= item.pin_button;
			load_value_s1 <= item.load_value;
		end
	end

	red_step_table u_table (
		.half_sel  (half_step_q),
		.state     (table_state_q),
		.code      (code_s1),
		.result    (lk)
	);

	assign load_ext = COUNT_WIDTH'(load_value_s1);
	assign pressed  = switch_present_q ? !pin_button_s1 : 1'b0;

	always_comb begin
		count_next  = count_q;
		state_next  = table_state_q;
		button_next = button_q;
		event_next  = 1'b0;
		dir_next    = DIR_ZERO;
		if (cmd_s1 == CMD_LOAD) begin
			count_next = load_ext;
		end else begin
			state_next  = lk.next_state;
			button_next = pressed;
			if (lk.cw) begin
				count_next = count_q + COUNT_WIDTH'(1);
				dir_next   = DIR_CW;
			end else if (lk.ccw) begin
				count_next = count_q - COUNT_WIDTH'(1);
				dir_next   = DIR_CCW;
			end
			event_next = lk.cw || lk.ccw || (pressed != button_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_state_q <= START_STATE;
			count_q       <= '0;
			button_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				table_state_q <= state_next;
				count_q       <= count_next;
				button_q      <= button_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			has_event_q  <= event_next;
			direction_q  <= dir_next;
			count_out_q  <= 32'(count_next);
			button_out_q <= button_next;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.has_event = has_event_q;
	assign result.direction = direction_q;
	assign result.count     = count_out_q;
	assign result.button    = button_out_q;

	// A reported step always comes with an event, and its code is never the unused one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (direction_q == DIR_ZERO || has_event_q))
		else $error("step reported without event");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (direction_q != 2'sb10))
		else $error("invalid direction code");

	// A load beat puts its value into the counter and leaves the table state alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd_s1 == CMD_LOAD) |=> (count_q == $past(load_ext)
			&& table_state_q == $past(table_state_q)))
		else $error("load did not take effect");

	// No table entry leads to the state with no row in either table.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd_s1 == CMD_SAMPLE) |=> (table_state_q != 3'd7))
		else $error("table reached an unused state");

endmodule

// ----- bench/rotary_encoder_decoder_tb.sv -----
// Self-checking testbench for the rotary encoder decoder: directed and random beats.
`timescale 1ns / 1ps

module rotary_encoder_decoder_tb;
	import red_pkg::*;

	localparam int   HOLD_LEN    = 64;
	localparam int   STALL_LIMIT = 4000;

	// Next state and step direction of both tables, rows by state, columns by code.
	localparam logic [2:0] FULL_NEXT [0:6][0:3] = '{
		'{3'd0, 3'd2, 3'd4, 3'd0},
		'{3'd3, 3'd0, 3'd1, 3'd0},
		'{3'd3, 3'd2, 3'd0, 3'd0},
		'{3'd3, 3'd2, 3'd1, 3'd0},
		'{3'd6, 3'd0, 3'd4, 3'd0},
		'{3'd6, 3'd5, 3'd0, 3'd0},
		'{3'd6, 3'd5, 3'd4, 3'd0}
	};
	localparam logic signed [1:0] FULL_DIR [0:6][0:3] = '{
		'{DIR_ZERO, DIR_ZERO, DIR_ZERO, DIR_ZERO},
		'{DIR_ZERO, DIR_ZERO, DIR_ZERO, DIR_CW},
		'{DIR_ZERO, DIR_ZERO, DIR_ZERO, DIR_ZERO},
		'{DIR_ZERO, DIR_ZERO, DIR_ZERO, DIR_ZERO},
		'{DIR_ZERO, DIR_ZERO, DIR_ZERO, DIR_ZERO},
		'{DIR_ZERO, DIR_ZERO, DIR_ZERO, DIR_CCW},
		'{DIR_ZERO, DIR_ZERO, DIR_ZERO, DIR_ZERO}
	};
	localparam logic [2:0] HALF_NEXT [0:5][0:3] = '{
		'{3'd3, 3'd2, 3'd1, 3'd0},
		'{3'd3, 3'd0, 3'd1, 3'd0},
		'{3'd3, 3'd2, 3'd0, 3'd0},
		'{3'd3, 3'd5, 3'd4, 3'd0},
		'{3'd3, 3'd3, 3'd4, 3'd0},
		'{3'd3, 3'd5, 3'd3, 3'd0}
	};
	localparam logic signed [1:0] HALF_DIR [0:5][0:3] = '{
		'{DIR_ZERO, DIR_ZERO, DIR_ZERO, DIR_ZERO},
		'{DIR_CCW,  DIR_ZERO, DIR_ZERO, DIR_ZERO},
		'{DIR_CW,   DIR_ZERO, DIR_ZERO, DIR_ZERO},
		'{DIR_ZERO, DIR_ZERO, DIR_ZERO, DIR_ZERO},
		'{DIR_ZERO, DIR_ZERO, DIR_ZERO, DIR_CW},
		'{DIR_ZERO, DIR_ZERO, DIR_ZERO, DIR_CCW}
	};

	// Pin codes in clockwise order, starting from the resting code 11.
	localparam logic [1:0] GRAY_CW [0:3] = '{2'b11, 2'b01, 2'b00, 2'b10};

	typedef struct {
		logic               cmd;
		logic               pin_a;
		logic               pin_b;
		logic               pin_button;
		logic signed [31:0] load_value;
	} sample_t;

	typedef struct {
		logic               has_event;
		logic signed [1:0]  direction;
		logic signed [31:0] count;
		logic               button;
	} decoded_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	red_item_if   item_ch ();
	red_result_if result_ch ();

	rotary_encoder_decoder uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	sample_t  pending_samples [$];
	decoded_t expected_results [$];

	// Decoder model state and register mirror.
	logic        half_mode;
	logic        switch_wired;
	logic [2:0]  state_model;
	logic [31:0] count_model;
	logic        button_model;

	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_arm;
	int   hold_count;
	int   idle_cycles;
	int   error_count;
	int   beats_sent;
	int   results_seen;
	int   events_seen;

	// Random walk of the encoder shaft.
	int   gray_pos;
	int   spin;
	logic btn_level;

	function automatic decoded_t decode_predict(input sample_t s);
		decoded_t          r;
		logic [1:0]        code;
		logic [2:0]        row;
		logic              pressed;
		logic signed [1:0] step;
		r.has_event = 1'b0;
		r.direction = DIR_ZERO;
		if (s.cmd == CMD_LOAD) begin
			count_model = s.load_value;
		end else begin
			code = {s.pin_a, s.pin_b};
			pressed = switch_wired ? ~s.pin_button : 1'b0;
			// A state with no row in the selected table acts as the start state.
			if (half_mode) begin
				row = (state_model >= HALF_ROWS) ? START_STATE : state_model;
				state_model = HALF_NEXT[row][code];
				step = HALF_DIR[row][code];
			end else begin
				row = (state_model >= FULL_ROWS) ? START_STATE : state_model;
				state_model = FULL_NEXT[row][code];
				step = FULL_DIR[row][code];
			end
			if (step == DIR_CW) begin
				count_model = count_model + 32'd1;
				r.has_event = 1'b1;
			end else if (step == DIR_CCW) begin
				count_model = count_model - 32'd1;
				r.has_event = 1'b1;
			end
			r.direction = step;
			if (pressed != button_model)
				r.has_event = 1'b1;
			button_model = pressed;
		end
		r.count = count_model;
		r.button = button_model;
		return r;
	endfunction

	// Driver: holds a beat until it is taken, then offers the next one or idles.
	always @(posedge clk) begin
		logic busy;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			busy = item_ch.valid;
			if (item_ch.valid && item_ch.ready) begin
				expected_results.push_back(decode_predict(pending_samples.pop_front()));
				beats_sent++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item_ch.valid      <= 1'b1;
					item_ch.cmd        <= pending_samples[0].cmd;
					item_ch.pin_a      <= pending_samples[0].pin_a;
					item_ch.pin_b      <= pending_samples[0].pin_b;
					item_ch.pin_button <= pending_samples[0].pin_button;
					item_ch.load_value <= pending_samples[0].load_value;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted from the moment it is armed.
	always @(posedge clk) begin
		if (!hold_arm)
			hold_count <= 0;
		else if (hold_count < HOLD_LEN)
			hold_count <= hold_count + 1;
	end

	// Monitor: checks each result beat against the oldest prediction.
	always @(posedge clk) begin
		decoded_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with nothing expected, count %0d",
						$time, result_ch.count);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (want.has_event)
						events_seen++;
					if (result_ch.has_event !== want.has_event) begin
						$display("%0t: has_event expected %0d got %0d",
							$time, want.has_event, result_ch.has_event);
						error_count++;
					end
					if (result_ch.direction !== want.direction) begin
						$display("%0t: direction expected %0d got %0d",
							$time, want.direction, result_ch.direction);
						error_count++;
					end
					if (result_ch.count !== want.count) begin
						$display("%0t: count expected %0d got %0d",
							$time, want.count, result_ch.count);
						error_count++;
					end
					if (result_ch.button !== want.button) begin
						$display("%0t: button expected %0d got %0d",
							$time, want.button, result_ch.button);
						error_count++;
					end
				end
			end
			result_ch.ready <= !(hold_arm && hold_count < HOLD_LEN)
				&& ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
				$time, idle_cycles, expected_results.size());
			$display("rotary_encoder_decoder_tb NOT OK");
			$finish;
		end
	end

	task automatic reg_write(input logic idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_HALF_STEP)
			half_mode = value[0];
		else
			switch_wired = value[0];
	endtask

	task automatic push_sample(input logic a, input logic b, input logic btn);
		sample_t s;
		s.cmd = CMD_SAMPLE;
		s.pin_a = a;
		s.pin_b = b;
		s.pin_button = btn;
		s.load_value = $urandom;
		pending_samples.push_back(s);
	endtask

	task automatic push_load(input logic signed [31:0] value);
		sample_t s;
		s.cmd = CMD_LOAD;
		s.pin_a = 1'($urandom_range(1));
		s.pin_b = 1'($urandom_range(1));
		s.pin_button = 1'($urandom_range(1));
		s.load_value = value;
		pending_samples.push_back(s);
	endtask

	task automatic wait_drain();
		while (pending_samples.size() != 0 || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Mostly clean rotation with bounces and direction changes, some noise and loads.
	task automatic push_random();
		int                 r;
		logic [1:0]         code;
		logic signed [31:0] v;
		r = $urandom_range(99);
		if (r < 3) begin
			case ($urandom_range(3))
				0: v = 32'sh7fffffff;
				1: v = 32'sh80000000;
				default: v = $urandom;
			endcase
			push_load(v);
		end else if (r < 11) begin
			push_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		end else begin
			if ($urandom_range(24) == 0)
				spin = -spin;
			r = $urandom_range(99);
			if (r < 12)
				gray_pos = (gray_pos - spin) & 3;
			else if (r >= 20)
				gray_pos = (gray_pos + spin) & 3;
			if ($urandom_range(29) == 0)
				btn_level = ~btn_level;
			code = GRAY_CW[gray_pos[1:0]];
			push_sample(code[1], code[0], btn_level);
		end
	endtask

	task automatic run_phase(input int n, input logic half, input logic wired,
			input int idle_pct, input int stall_pct, input logic hold);
		int left;
		int chunk;
		reg_write(REG_HALF_STEP, {31'd0, half});
		reg_write(REG_SWITCH, {31'd0, wired});
		@(negedge clk);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		hold_arm = hold;
		left = n;
		while (left > 0) begin
			chunk = $urandom_range(80, 20);
			if (chunk > left)
				chunk = left;
			repeat (chunk) push_random();
			left -= chunk;
			if ($urandom_range(1))
				wait_drain();
			else
				repeat ($urandom_range(40, 1)) @(negedge clk);
		end
		wait_drain();
		hold_arm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_SAMPLE;
		item_ch.pin_a = 1'b1;
		item_ch.pin_b = 1'b1;
		item_ch.pin_button = 1'b1;
		item_ch.load_value = '0;
		result_ch.ready = 1'b0;
		half_mode = 1'b0;
		switch_wired = 1'b1;
		state_model = START_STATE;
		count_model = '0;
		button_model = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_arm = 1'b0;
		idle_cycles = 0;
		error_count = 0;
		beats_sent = 0;
		results_seen = 0;
		events_seen = 0;
		gray_pos = 0;
		spin = 1;
		btn_level = 1'b1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Full step, button wired: both counter wraps, button press, bounce.
		reg_write(REG_HALF_STEP, 32'd0);
		reg_write(REG_SWITCH, 32'd1);
		@(negedge clk);
		push_load(32'sh7fffffff);
		push_sample(0, 1, 1);
		push_sample(0, 0, 1);
		push_sample(1, 0, 1);
		push_sample(1, 1, 1);
		push_sample(1, 0, 1);
		push_sample(0, 0, 1);
		push_sample(0, 1, 1);
		push_sample(1, 1, 1);
		push_sample(1, 1, 0);
		push_sample(1, 1, 0);
		push_sample(1, 1, 1);
		push_sample(0, 1, 1);
		push_sample(1, 1, 1);
		// Leave the table in its last full-step state with the button held.
		push_sample(1, 0, 0);
		push_sample(0, 0, 0);
		wait_drain();

		// Half step reads that state as the start; the missing button releases the latch.
		reg_write(REG_HALF_STEP, 32'd1);
		reg_write(REG_SWITCH, 32'd0);
		@(negedge clk);
		push_sample(0, 1, 0);
		push_sample(0, 0, 0);
		push_sample(1, 0, 0);
		push_sample(1, 1, 0);
		push_load(32'sh80000000);
		push_sample(1, 0, 1);
		push_sample(0, 0, 1);
		wait_drain();

		run_phase(250, 1'b0, 1'b1, 0, 0, 1'b0);
		run_phase(250, 1'b1, 1'b1, 67, 0, 1'b0);
		run_phase(250, 1'b0, 1'b0, 0, 67, 1'b0);
		run_phase(250, 1'b1, 1'b0, 28, 28, 1'b0);
		run_phase(150, 1'b0, 1'b1, 0, 0, 1'b1);
		run_phase(250, 1'b1, 1'b1, 28, 28, 1'b0);

		repeat (10) @(negedge clk);
		$display("Sent %0d input beats and checked %0d result beats, %0d of them events.",
			beats_sent, results_seen, events_seen);
		$display("Covered both step tables, button wired and absent, loads, wraps and stalls.");
		if (error_count == 0)
			$display("rotary_encoder_decoder_tb OK");
		else
			$display("rotary_encoder_decoder_tb NOT OK");
		$finish;
	end

endmodule
